@@ hdl/efg_pkg.sv @@
package efg_pkg;

  localparam int WAITERS_DEF    = 8;
  localparam int FLAG_WIDTH_DEF = 32;
  localparam int PAT_W          = 32;
  localparam int TASK_W         = 8;
  localparam int STATUS_W       = 4;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_WAIT   = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_WOKEN      = 4'd0,
    ST_SET_DONE   = 4'd1,
    ST_CLEARED    = 4'd2,
    ST_WAIT_DONE  = 4'd3,
    ST_WAIT_FAIL  = 4'd4,
    ST_QUEUED     = 4'd5,
    ST_QUEUE_FULL = 4'd6,
    ST_CANCELLED  = 4'd7,
    ST_NOT_FOUND  = 4'd8
  } status_t;

  // Decoded request handed from the front end to the back end.
  typedef struct packed {
    op_t               op;
    logic [PAT_W-1:0]  pattern;
    logic [TASK_W-1:0] task_id;
    logic              wait_any;
    logic              wait_all;
    logic              clear_all;
    logic              clear_matched;
    logic              fail_if_blocked;
  } req_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_WALK,
    BE_CANCEL
  } be_state_t;

endpackage

@@ hdl/event_flag_group_unit_top.sv @@
// Event flag group: a flag word plus a FIFO of up to WAITERS blocked tasks.
// Requests enter through a two-deep queue and are executed by a back end
// that emits results into a one-entry output register. Clear and wait are
// taken and answered together. A set request first merges the pattern,
// then visits the waiters in order (a woken waiter is dropped in place and
// the same slot is visited again), then emits the final result. A cancel
// starts, then scans the waiters for its task, then emits its result.
// Every request ends with a result flagged last.
module event_flag_group_unit_top
  import efg_pkg::*;
#(
  parameter int WAITERS    = WAITERS_DEF,
  parameter int FLAG_WIDTH = FLAG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode,
  input  logic [PAT_W-1:0]  pattern,
  input  logic [TASK_W-1:0] task_id,
  input  logic              wait_any,
  input  logic              wait_all,
  input  logic              clear_all,
  input  logic              clear_matched,
  input  logic              poll,
  input  logic              may_block,
  output logic              empty,
  input  logic              pop,
  output logic [TASK_W-1:0] task_id_res,
  output logic [3:0]        status,
  output logic [PAT_W-1:0]  matched_bits,
  output logic [PAT_W-1:0]  flag_value,
  output logic              last
);

  logic req_valid;
  logic req_take;
  req_t req;

  // Front end: decode and hold requests.
  efg_front u_front (
    .clk, .rst, .push, .full, .opcode, .pattern, .task_id, .wait_any,
    .wait_all, .clear_all, .clear_matched, .poll, .may_block,
    .req_valid, .req, .req_take
  );

  // Back end: flag word, waiter queue, result register.
  efg_back #(.WAITERS(WAITERS), .FLAG_WIDTH(FLAG_WIDTH)) u_back (
    .clk, .rst, .req_valid, .req, .req_take, .empty, .pop,
    .task_id_res, .status, .matched_bits, .flag_value, .last
  );

endmodule

@@ hdl/efg_front.sv @@
module efg_front
  import efg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode,
  input  logic [PAT_W-1:0]  pattern,
  input  logic [TASK_W-1:0] task_id,
  input  logic              wait_any,
  input  logic              wait_all,
  input  logic              clear_all,
  input  logic              clear_matched,
  input  logic              poll,
  input  logic              may_block,
  output logic              req_valid,
  output req_t              req,
  input  logic              req_take
);

  // Two-entry request queue.
  req_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] cnt;
  req_t       dec;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    dec.op              = op_t'(opcode);
    dec.pattern         = pattern;
    dec.task_id         = task_id;
    dec.wait_any        = wait_any;
    dec.wait_all        = wait_all;
    dec.clear_all       = clear_all;
    dec.clear_matched   = clear_matched;
    dec.fail_if_blocked = poll | ~may_block;
  end

  assign full      = (cnt == 2'd2);
  assign req_valid = (cnt != 2'd0);
  assign req       = q[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = req_take & req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/efg_back.sv @@
module efg_back
  import efg_pkg::*;
#(
  parameter int WAITERS    = WAITERS_DEF,
  parameter int FLAG_WIDTH = FLAG_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  req_t              req,
  output logic              req_take,
  output logic              empty,
  input  logic              pop,
  output logic [TASK_W-1:0] task_id_res,
  output logic [3:0]        status,
  output logic [PAT_W-1:0]  matched_bits,
  output logic [PAT_W-1:0]  flag_value,
  output logic              last
);

  localparam int IW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int CW = $clog2(WAITERS + 1);

  typedef struct packed {
    logic [TASK_W-1:0]     task_id;
    logic [FLAG_WIDTH-1:0] pattern;
    logic                  any;
    logic                  all;
    logic                  clr_all;
    logic                  clr_matched;
  } waiter_t;

  waiter_t               wq [WAITERS];
  logic [CW-1:0]         count;
  logic [FLAG_WIDTH-1:0] flags;
  be_state_t             state, state_next;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         rm_idx;
  logic                  rm_en;

  // Result register.
  logic                  out_full;
  logic [TASK_W-1:0]     o_task;
  logic [3:0]            o_status;
  logic [FLAG_WIDTH-1:0] o_ret;
  logic [FLAG_WIDTH-1:0] o_flags;
  logic                  o_last;
  logic                  can_emit;

  assign empty        = ~out_full;
  assign task_id_res  = o_task;
  assign status       = o_status;
  assign matched_bits = PAT_W'(o_ret);
  assign flag_value   = PAT_W'(o_flags);
  assign last         = o_last;
  assign can_emit     = ~out_full | pop;

  logic [FLAG_WIDTH-1:0] rpat, m_in, m_w;
  logic                  ok_in, ok_w;
  waiter_t               cur;
  logic [FLAG_WIDTH-1:0] set_flags;

  assign rpat = FLAG_WIDTH'(req.pattern);
  assign m_in = flags & rpat;
  assign ok_in = req.wait_any ? (m_in != '0) : (req.wait_all & (m_in == rpat));
  assign cur  = wq[idx[IW-1:0]];
  assign m_w  = flags & cur.pattern;
  assign ok_w = cur.any ? (m_w != '0) : (cur.all & (m_w == cur.pattern));
  assign set_flags = flags | rpat;

  logic                  emit;
  logic [TASK_W-1:0]     e_task;
  logic [3:0]            e_status;
  logic [FLAG_WIDTH-1:0] e_ret;
  logic                  e_last;
  logic [FLAG_WIDTH-1:0] flags_next;
  logic [CW-1:0]         idx_next;
  logic                  enq;

  always_comb begin
    state_next = state;
    req_take   = 1'b0;
    emit       = 1'b0;
    e_task     = '0;
    e_status   = ST_SET_DONE;
    e_ret      = '0;
    e_last     = 1'b1;
    flags_next = flags;
    idx_next   = idx;
    rm_en      = 1'b0;
    rm_idx     = idx;
    enq        = 1'b0;
    case (state)
      BE_IDLE: begin
        if (req_valid) begin
          case (req.op)
            OP_SET: begin
              req_take   = 1'b1;
              flags_next = set_flags;
              idx_next   = '0;
              state_next = BE_WALK;
            end
            OP_CLEAR: begin
              if (can_emit) begin
                req_take   = 1'b1;
                flags_next = flags & ~rpat;
                emit       = 1'b1;
                e_status   = ST_CLEARED;
              end
            end
            OP_WAIT: begin
              if (can_emit) begin
                req_take = 1'b1;
                emit     = 1'b1;
                e_task   = req.task_id;
                if (ok_in) begin
                  e_status = ST_WAIT_DONE;
                  e_ret    = m_in;
                  if (req.clear_all) flags_next = '0;
                  else if (req.clear_matched) flags_next = flags & ~m_in;
                end else if (req.fail_if_blocked) begin
                  e_status = ST_WAIT_FAIL;
                end else if (count >= CW'(WAITERS)) begin
                  e_status = ST_QUEUE_FULL;
                end else begin
                  e_status = ST_QUEUED;
                  enq      = 1'b1;
                end
              end
            end
            OP_CANCEL: begin
              idx_next   = '0;
              state_next = BE_CANCEL;
            end
            default: ;
          endcase
        end
      end
      BE_WALK: begin
        // Set request taken; visit one waiter a cycle while can_emit.
        if (can_emit) begin
          if (idx < count && flags != '0) begin
            if (ok_w) begin
              emit     = 1'b1;
              e_task   = cur.task_id;
              e_status = ST_WOKEN;
              e_ret    = m_w;
              e_last   = 1'b0;
              rm_en    = 1'b1;
              if (cur.clr_all) flags_next = '0;
              else if (cur.clr_matched) flags_next = flags & ~m_w;
            end else begin
              idx_next = idx + CW'(1);
            end
          end else begin
            emit       = 1'b1;
            e_status   = ST_SET_DONE;
            state_next = BE_IDLE;
          end
        end
      end
      BE_CANCEL: begin
        if (idx < count && cur.task_id != req.task_id) begin
          idx_next = idx + CW'(1);
        end else if (can_emit) begin
          req_take   = 1'b1;
          emit       = 1'b1;
          e_task     = req.task_id;
          state_next = BE_IDLE;
          if (idx < count) begin
            e_status = ST_CANCELLED;
            rm_en    = 1'b1;
          end else begin
            e_status = ST_NOT_FOUND;
          end
        end
      end
      default: state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    // Waiter queue: shift down to drop an entry, append at the tail.
    for (int i = 0; i < WAITERS; i++) begin
      if (rm_en && CW'(i) >= rm_idx && i < WAITERS - 1) begin
        wq[i] <= wq[i+1];
      end
    end
    if (enq) begin
      wq[count[IW-1:0]] <= '{req.task_id, rpat, req.wait_any, req.wait_all,
                             req.clear_all, req.clear_matched};
    end
    if (emit) begin
      o_task   <= e_task;
      o_status <= e_status;
      o_ret    <= e_ret;
      o_flags  <= flags_next;
      o_last   <= e_last;
    end
    idx <= idx_next;
    if (rst) begin
      state    <= BE_IDLE;
      flags    <= '0;
      count    <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      flags <= flags_next;
      if (enq) count <= count + CW'(1);
      else if (rm_en) count <= count - CW'(1);
      if (emit) out_full <= 1'b1;
      else if (pop) out_full <= 1'b0;
    end
  end

endmodule
